@@ sv/tdps_pkg.sv @@
// Shared types and constants for the tick-driven process scheduler.
// No dependencies; every other file refers to this package by scoped names.
package tdps_pkg;

  localparam int ENTRIES  = 8;
  localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int TIME_W   = 16;
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 4;
  localparam int FSLOT_W  = 3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic MODE_SRT  = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [FSLOT_W-1:0] slot;
    logic [ID_W-1:0]   process_id;
    logic [TIME_W-1:0] arrival_in;
    logic [TIME_W-1:0] burst_in;
    logic [PRIO_W-1:0] priority_in;
  } in_t;

  typedef struct packed {
    logic               ran;
    logic [FSLOT_W-1:0] run_slot;
    logic [ID_W-1:0]    run_id;
    logic [PRIO_W-1:0]  run_priority;
    logic [TIME_W-1:0]  remaining_after;
    logic [TIME_W-1:0]  time_after;
    logic               finished;
    logic               all_done;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] remaining;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // One write port into the table: a full load or a remaining-time update.
  typedef struct packed {
    logic              en;
    logic              full;
    logic [SLOT_W-1:0] addr;
    entry_t            entry;
  } tbl_wr_t;

endpackage

@@ sv/tdps_table.sv @@
// Process table: identifier, arrival, remaining time and priority per slot.
// Depends on tdps_pkg. One read address and one write port per cycle.
module tdps_table (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [tdps_pkg::SLOT_W-1:0] rd_addr,
  output tdps_pkg::entry_t        rd_entry,
  input  tdps_pkg::tbl_wr_t       wr
);

  logic [tdps_pkg::ID_W-1:0]   ident     [tdps_pkg::ENTRIES];
  logic [tdps_pkg::TIME_W-1:0] arrival   [tdps_pkg::ENTRIES];
  logic [tdps_pkg::TIME_W-1:0] remaining [tdps_pkg::ENTRIES];
  logic [tdps_pkg::PRIO_W-1:0] prio      [tdps_pkg::ENTRIES];

  // Only the remaining time needs clearing: an entry with zero remaining
  // time is never selected, and a load rewrites every field together.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tdps_pkg::ENTRIES; k++) begin
        remaining[k] <= '0;
      end
    end else if (wr.en) begin
      remaining[wr.addr] <= wr.entry.remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.full) begin
      ident[wr.addr]   <= wr.entry.ident;
      arrival[wr.addr] <= wr.entry.arrival;
      prio[wr.addr]    <= wr.entry.prio;
    end
  end

  assign rd_entry.ident     = ident[rd_addr];
  assign rd_entry.arrival   = arrival[rd_addr];
  assign rd_entry.remaining = remaining[rd_addr];
  assign rd_entry.prio      = prio[rd_addr];

endmodule

@@ sv/tick_driven_process_scheduler_unit.sv @@
// Latency: a load transaction takes effect at its accepting edge. A tick, accepted in
// S_IDLE, passes each entry in turn through the shared comparator in S_SCAN; S_UPDATE
// then writes back the decrement and registers the result.
// Throughput: loads back to back while idle; a new tick is taken only in the idle
// state after the write-back, so it waits until the last tick is done. A stalled
// result holds the write-back step. Reset (rst, synchronous): clears time, mode,
// remaining times and the output valid flag.
module tick_driven_process_scheduler_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic            cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  tdps_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output tdps_pkg::out_t  out_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} state_t;

  state_t                        state;
  logic [tdps_pkg::SLOT_W-1:0]   idx;
  logic                          found;
  logic [tdps_pkg::SLOT_W-1:0]   best_slot;
  logic [tdps_pkg::TIME_W-1:0]   best_rem;
  logic [tdps_pkg::PRIO_W-1:0]   best_prio;
  logic [tdps_pkg::ID_W-1:0]     best_id;
  logic [tdps_pkg::CNT_W-1:0]    nz_count;
  logic                          policy_mode;
  logic [tdps_pkg::TIME_W-1:0]   current_time;

  tdps_pkg::entry_t              rd_entry;
  tdps_pkg::tbl_wr_t             wr;
  logic                          accept;
  logic                          eligible;
  logic                          better;
  logic                          out_free;
  logic                          slot_ok;
  logic [tdps_pkg::TIME_W-1:0]   rem_dec;
  logic [tdps_pkg::TIME_W-1:0]   time_next;
  logic                          all_done_next;

  tdps_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign slot_ok  = (32'(in_data.slot) < tdps_pkg::ENTRIES);

  // Shared comparator: the entry at idx against the best so far.
  assign eligible = (rd_entry.arrival <= current_time) && (rd_entry.remaining != '0);
  always_comb begin
    if (!found) begin
      better = 1'b1;
    end else if (policy_mode == tdps_pkg::MODE_PRIO) begin
      better = rd_entry.prio < best_prio;
    end else begin
      better = rd_entry.remaining < best_rem;
    end
  end

  assign rem_dec   = best_rem - 1'b1;
  assign time_next = (current_time == tdps_pkg::TIME_MAX) ? current_time
                                                          : current_time + 1'b1;
  // The served entry was counted as non-zero during the scan.
  assign all_done_next = (nz_count == '0) ||
                         ((nz_count == tdps_pkg::CNT_W'(1)) && found && (rem_dec == '0));

  always_comb begin
    wr = '0;
    if (state == S_IDLE) begin
      wr.en              = accept && (in_data.kind == tdps_pkg::KIND_LOAD) && slot_ok;
      wr.full            = 1'b1;
      wr.addr            = tdps_pkg::SLOT_W'(in_data.slot);
      wr.entry.ident     = in_data.process_id;
      wr.entry.arrival   = in_data.arrival_in;
      wr.entry.remaining = in_data.burst_in;
      wr.entry.prio      = in_data.priority_in;
    end else if (state == S_UPDATE) begin
      wr.en              = out_free && found;
      wr.full            = 1'b0;
      wr.addr            = best_slot;
      wr.entry.remaining = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      found        <= 1'b0;
      nz_count     <= '0;
      policy_mode  <= tdps_pkg::MODE_SRT;
      current_time <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        policy_mode <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (in_data.kind == tdps_pkg::KIND_TICK)) begin
            idx      <= '0;
            found    <= 1'b0;
            nz_count <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_entry.remaining != '0) begin
            nz_count <= nz_count + 1'b1;
          end
          if (eligible && better) begin
            found     <= 1'b1;
            best_slot <= idx;
            best_rem  <= rd_entry.remaining;
            best_prio <= rd_entry.prio;
            best_id   <= rd_entry.ident;
          end
          if (idx == tdps_pkg::SLOT_W'(tdps_pkg::ENTRIES - 1)) begin
            state <= S_UPDATE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_UPDATE: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.ran             <= found;
            out_data.run_slot        <= found ? tdps_pkg::FSLOT_W'(best_slot) : '0;
            out_data.run_id          <= found ? best_id : '0;
            out_data.run_priority    <= found ? best_prio : '0;
            out_data.remaining_after <= found ? rem_dec : '0;
            out_data.finished        <= found && (rem_dec == '0);
            out_data.time_after      <= time_next;
            out_data.all_done        <= all_done_next;
            current_time             <= time_next;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/tdps_checker.sv @@
// Port-level checks for the tick-driven process scheduler.
// Depends on tdps_pkg; bound to tick_driven_process_scheduler_unit below.
module tdps_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_stall,
  input tdps_pkg::out_t out_data
);

  // A result waiting on a stalled receiver keeps its transaction intact.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  // An idle tick reports nothing about any entry.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ran |->
      out_data.run_slot == '0 && out_data.run_id == '0 &&
      out_data.run_priority == '0 && out_data.remaining_after == '0 &&
      !out_data.finished)
    else $error("idle tick carries entry data");

  a_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.finished |-> out_data.ran && out_data.remaining_after == '0)
    else $error("finished without a served entry at zero");

  // If nothing is left, the entry just served must have run out.
  a_all_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.all_done && out_data.ran |-> out_data.finished)
    else $error("all done while the served entry still has time");

endmodule

bind tick_driven_process_scheduler_unit tdps_checker u_tdps_checker (.*);
